// ===== sv/tupl_pkg.sv =====
// Shared types, sizes and codes for the threshold union of posting lists.
package tupl_pkg;

  localparam int NUM_LISTS  = 8;
  localparam int LIST_DEPTH = 1024;

  localparam int DOC_W     = 31;
  localparam int SCORE_W   = 32;
  localparam int CMD_W     = 3;
  localparam int LIST_W    = 3;
  localparam int MIN_W     = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 4;

  localparam int IDX_W     = $clog2(NUM_LISTS);
  localparam int RDX_W     = $clog2(NUM_LISTS + 1);
  localparam int CNT_W     = $clog2(NUM_LISTS + 1);
  localparam int CUR_W     = $clog2(LIST_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_LISTS * LIST_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  localparam logic [DOC_W-1:0] DOC_END = '1;

  typedef enum logic [CMD_W-1:0] {
    OP_CLEAR   = 3'd0,
    OP_APPEND  = 3'd1,
    OP_START   = 3'd2,
    OP_ADVANCE = 3'd3,
    OP_SEEK    = 3'd4
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_MATCHES = 1'b0,
    REG_SUM_SCORES  = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SEEK_CHK,
    S_MIN_INIT,
    S_MIN_RUN,
    S_MIN_EVAL,
    S_CNT_INIT,
    S_CNT_RUN,
    S_CNT_EVAL,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic append;
    logic start_init;
    logic scan_begin;
    logic scan_run;
    logic scan_cnt;
    logic set_finished;
    logic take_match;
    logic out_load;
  } ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             finished;
    logic             seek_more;
    logic             scan_last;
    logic             any;
    logic             count_ok;
    logic             out_free;
  } sts_t;

endpackage

// ===== sv/tupl_if.sv =====
// Request and response channel interfaces.
interface tupl_req_if import tupl_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [LIST_W-1:0]  list_index;
  logic [DOC_W-1:0]   doc_id;
  logic [SCORE_W-1:0] posting_score;
  logic [DOC_W-1:0]   seek_target;

  modport source (output valid, command, list_index, doc_id, posting_score, seek_target,
                  input ready);
  modport sink (input valid, command, list_index, doc_id, posting_score, seek_target,
                output ready);
endinterface

interface tupl_rsp_if import tupl_pkg::*;;
  logic               valid;
  logic               ready;
  logic [DOC_W-1:0]   match_doc;
  logic [SCORE_W-1:0] match_score;
  logic               terminated;
  logic               overflowed;

  modport source (output valid, match_doc, match_score, terminated, overflowed,
                  input ready);
  modport sink (input valid, match_doc, match_score, terminated, overflowed,
                output ready);
endinterface

// ===== sv/threshold_union_of_posting_lists_core.sv =====
// Top level of the threshold union of posting lists merge engine.
//
//  channel | dir | words
//  --------+-----+------------------------------------------------------------
//  req     | in  | command, list_index, doc_id, posting_score, seek_target
//  rsp     | out | match_doc, match_score, terminated, overflowed
//  cfg     | in  | cfg_write, cfg_index, cfg_data (min_matches, sum_scores)
//
// Clear and append finish in the decode state. Each merge step scans all list heads
// twice through the posting memory read port, a minimum pass and then a count pass,
// and skips the count pass when no head is left; steps repeat until a document meets
// the threshold or the lists run out, and seek repeats steps until the match reaches its target.
// Reset is synchronous and needs no clearing pass. One word is in flight at a time;
// a finished result waits in the output register while the next word is accepted.
module threshold_union_of_posting_lists_core import tupl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  tupl_req_if.sink             req,
  tupl_rsp_if.source           rsp,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  ctl_t ctl;
  sts_t sts;

  tupl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  tupl_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .command       (req.command),
    .list_index    (req.list_index),
    .doc_id        (req.doc_id),
    .posting_score (req.posting_score),
    .seek_target   (req.seek_target),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .ctl           (ctl),
    .sts           (sts),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .match_doc     (rsp.match_doc),
    .match_score   (rsp.match_score),
    .terminated    (rsp.terminated),
    .overflowed    (rsp.overflowed)
  );

endmodule

// ===== sv/tupl_ram.sv =====
// Generic single write port RAM with registered read.
module tupl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/tupl_dp.sv =====
// Datapath: list storage, cursors, merge scan, match registers and result register.
module tupl_dp import tupl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [CMD_W-1:0]     command,
  input  logic [LIST_W-1:0]    list_index,
  input  logic [DOC_W-1:0]     doc_id,
  input  logic [SCORE_W-1:0]   posting_score,
  input  logic [DOC_W-1:0]     seek_target,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  ctl_t                 ctl,
  output sts_t                 sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DOC_W-1:0]     match_doc,
  output logic [SCORE_W-1:0]   match_score,
  output logic                 terminated,
  output logic                 overflowed
);

  logic [CMD_W-1:0]   op;
  logic [LIST_W-1:0]  lst;
  logic [DOC_W-1:0]   doc;
  logic [SCORE_W-1:0] score;
  logic [DOC_W-1:0]   tgt;

  logic [MIN_W-1:0]   min_matches;
  logic               sum_scores;

  logic [CUR_W-1:0]   lens [NUM_LISTS];
  logic [CUR_W-1:0]   curs [NUM_LISTS];
  logic [DOC_W-1:0]   last_doc [NUM_LISTS];

  logic [DOC_W-1:0]   cur_doc;
  logic [SCORE_W-1:0] cur_score;
  logic               finished;
  logic               overflow;

  logic [RDX_W-1:0]   rd_idx;
  logic [IDX_W-1:0]   use_idx;
  logic               use_vld;
  logic               use_act;
  logic               any;
  logic [DOC_W-1:0]   low;
  logic [CNT_W-1:0]   count;
  logic [SCORE_W-1:0] total;

  logic [IDX_W-1:0]   lst_ix;
  logic [IDX_W-1:0]   rd_sel;
  logic [IDX_W-1:0]   sel;
  logic [CUR_W-1:0]   len_sel;
  logic [CUR_W-1:0]   cur_sel;
  logic               rd_go;
  logic               list_ok;
  logic               app_full;
  logic               app_write;
  logic [ADDR_W-1:0]  waddr;
  logic [ADDR_W-1:0]  raddr;
  logic [DOC_W-1:0]   rd_doc;
  logic [SCORE_W-1:0] rd_score;
  logic [SCORE_W:0]   sum;
  logic [MIN_W-1:0]   need;

  assign lst_ix  = IDX_W'(lst);
  assign rd_sel  = rd_idx[IDX_W-1:0];
  assign rd_go   = 32'(rd_idx) < NUM_LISTS;
  assign sel     = ctl.append ? lst_ix : rd_sel;
  assign len_sel = lens[sel];
  assign cur_sel = curs[rd_sel];

  assign list_ok   = (32'(lst) < NUM_LISTS) && (doc != DOC_END);
  assign app_full  = 32'(len_sel) >= LIST_DEPTH;
  assign app_write = ctl.append && list_ok && !app_full &&
                     !((len_sel != '0) && (doc <= last_doc[lst_ix]));

  assign waddr = ADDR_W'(lst_ix) * ADDR_W'(LIST_DEPTH) + ADDR_W'(len_sel);
  assign raddr = ADDR_W'(rd_sel) * ADDR_W'(LIST_DEPTH) + ADDR_W'(cur_sel);

  assign sum  = {1'b0, total} + {1'b0, rd_score};
  assign need = (min_matches == '0) ? MIN_W'(1) : min_matches;

  assign sts.op        = op;
  assign sts.finished  = finished;
  assign sts.seek_more = cur_doc < tgt;
  assign sts.scan_last = use_vld && (32'(use_idx) == NUM_LISTS - 1);
  assign sts.any       = any;
  assign sts.count_ok  = 32'(count) >= 32'(need);
  assign sts.out_free  = !out_valid || out_ready;

  tupl_ram #(.WIDTH(DOC_W), .DEPTH(MEM_DEPTH)) u_docs (
    .clk   (clk),
    .we    (app_write),
    .waddr (waddr),
    .wdata (doc),
    .raddr (raddr),
    .rdata (rd_doc)
  );

  tupl_ram #(.WIDTH(SCORE_W), .DEPTH(MEM_DEPTH)) u_scores (
    .clk   (clk),
    .we    (app_write),
    .waddr (waddr),
    .wdata (score),
    .raddr (raddr),
    .rdata (rd_score)
  );

  // latch the accepted word
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op    <= command;
      lst   <= list_index;
      doc   <= doc_id;
      score <= posting_score;
      tgt   <= seek_target;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_matches <= MIN_W'(2);
      sum_scores  <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MIN_MATCHES: min_matches <= cfg_data[MIN_W-1:0];
        REG_SUM_SCORES:  sum_scores  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (app_write) begin
      last_doc[lst_ix] <= doc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        lens[i] <= '0;
        curs[i] <= '0;
      end
      cur_doc   <= '0;
      cur_score <= '0;
      finished  <= 1'b1;
      overflow  <= 1'b0;
    end else begin
      if (ctl.append && list_ok && app_full) begin
        overflow <= 1'b1;
      end
      if (app_write) begin
        lens[lst_ix] <= len_sel + CUR_W'(1);
      end
      if (ctl.start_init) begin
        for (int i = 0; i < NUM_LISTS; i++) begin
          curs[i] <= '0;
        end
        finished  <= 1'b0;
        cur_doc   <= '0;
        cur_score <= '0;
      end
      // step past every head that holds the low document
      if (ctl.scan_run && ctl.scan_cnt && use_vld && use_act && rd_doc == low) begin
        curs[use_idx] <= curs[use_idx] + CUR_W'(1);
      end
      if (ctl.set_finished) begin
        finished  <= 1'b1;
        cur_score <= '0;
      end
      if (ctl.take_match) begin
        cur_doc   <= low;
        cur_score <= sum_scores ? total : '0;
      end
    end
  end

  // scan pipeline: read head of rd_idx, use head of use_idx in the cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx  <= '0;
      use_vld <= 1'b0;
      any     <= 1'b0;
      count   <= '0;
    end else if (ctl.scan_begin) begin
      rd_idx  <= '0;
      use_vld <= 1'b0;
      any     <= 1'b0;
      count   <= '0;
      total   <= '0;
    end else if (ctl.scan_run) begin
      if (rd_go) begin
        rd_idx <= rd_idx + RDX_W'(1);
      end
      use_vld <= rd_go;
      use_idx <= rd_sel;
      use_act <= cur_sel < len_sel;
      if (use_vld && use_act) begin
        if (!ctl.scan_cnt) begin
          if (!any || rd_doc < low) begin
            low <= rd_doc;
            any <= 1'b1;
          end
        end else if (rd_doc == low) begin
          count <= count + CNT_W'(1);
          total <= sum[SCORE_W] ? '1 : sum[SCORE_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      match_doc   <= finished ? '0 : cur_doc;
      match_score <= finished ? '0 : cur_score;
      terminated  <= finished;
      overflowed  <= overflow;
    end
  end

endmodule

// ===== sv/tupl_ctrl.sv =====
// Controller: command decode and merge sequencing.
module tupl_ctrl import tupl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output ctl_t ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.op)
          OP_CLEAR: begin
            ctl.clear  = 1'b1;
            state_next = S_IDLE;
          end
          OP_APPEND: begin
            ctl.append = 1'b1;
            state_next = S_IDLE;
          end
          OP_START: begin
            ctl.start_init = 1'b1;
            state_next     = S_MIN_INIT;
          end
          OP_ADVANCE: state_next = sts.finished ? S_OUT : S_MIN_INIT;
          OP_SEEK:    state_next = S_SEEK_CHK;
          default:    state_next = S_IDLE;
        endcase
      end
      S_SEEK_CHK: begin
        state_next = (sts.finished || !sts.seek_more) ? S_OUT : S_MIN_INIT;
      end
      S_MIN_INIT: begin
        ctl.scan_begin = 1'b1;
        state_next     = S_MIN_RUN;
      end
      S_MIN_RUN: begin
        ctl.scan_run = 1'b1;
        if (sts.scan_last) begin
          state_next = S_MIN_EVAL;
        end
      end
      S_MIN_EVAL: begin
        if (!sts.any) begin
          ctl.set_finished = 1'b1;
          state_next       = S_OUT;
        end else begin
          state_next = S_CNT_INIT;
        end
      end
      S_CNT_INIT: begin
        ctl.scan_begin = 1'b1;
        ctl.scan_cnt   = 1'b1;
        state_next     = S_CNT_RUN;
      end
      S_CNT_RUN: begin
        ctl.scan_run = 1'b1;
        ctl.scan_cnt = 1'b1;
        if (sts.scan_last) begin
          state_next = S_CNT_EVAL;
        end
      end
      S_CNT_EVAL: begin
        if (sts.count_ok) begin
          ctl.take_match = 1'b1;
          state_next     = (sts.op == OP_SEEK) ? S_SEEK_CHK : S_OUT;
        end else begin
          state_next = S_MIN_INIT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
